// ===== hdl/pbzl_pkg.sv =====
// Shared types, constants and state encoding for the prefix bucket code lookup.
package pbzl_pkg;

	// Directory geometry: one slot per three-digit prefix plus a closing slot.
	localparam int DIR_SLOTS = 1001;
	localparam int DIR_AW    = $clog2(DIR_SLOTS);

	// Default size of the record store.
	localparam int RECORD_SLOTS_DEF = 65536;

	// Character codes used to check and convert the code text.
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam int         CODE_CHARS = 5;

	// Operation codes carried in the mode field.
	localparam logic [1:0] MODE_DIR_WRITE = 2'd0;
	localparam logic [1:0] MODE_REC_WRITE = 2'd1;
	localparam logic [1:0] MODE_LOOKUP    = 2'd2;

	// Result status codes.
	localparam logic [1:0] STATUS_FOUND     = 2'd0;
	localparam logic [1:0] STATUS_INVALID   = 2'd1;
	localparam logic [1:0] STATUS_CORRUPT   = 2'd2;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

	// One input beat.
	typedef struct packed {
		logic [1:0]         mode;
		logic [15:0]        load_index;
		logic [15:0]        dir_value;
		logic [7:0]         rec_suffix;
		logic signed [15:0] rec_latitude;
		logic signed [15:0] rec_longitude;
		logic [39:0]        zip_text;
		logic [7:0]         zip_terminator;
	} item_t;

	// One result beat.
	typedef struct packed {
		logic [1:0]         status;
		logic signed [15:0] latitude;
		logic signed [15:0] longitude;
	} result_t;

	// One entry of the record store.
	typedef struct packed {
		logic [7:0]         suffix;
		logic signed [15:0] latitude;
		logic signed [15:0] longitude;
	} rec_t;

	// Decoded code text handed from the decoder to the sequencer.
	typedef struct packed {
		logic                bad;
		logic [DIR_AW-1:0]   prefix;
		logic [6:0]          suffix;
	} dec_t;

	// Lookup sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_DIR_START,
		ST_DIR_END,
		ST_SCAN
	} state_t;

endpackage

// ===== hdl/pbzl_decode.sv =====
// Code text checker: validates five digits and the terminator, forms prefix and suffix.
module pbzl_decode
	import pbzl_pkg::*;
(
	input  logic        clk,
	input  logic        load,
	input  logic [39:0] zip_text,
	input  logic [7:0]  zip_terminator,
	output dec_t        dec_q
);

	logic [7:0] ch     [CODE_CHARS];
	logic [3:0] digit  [CODE_CHARS];
	logic       bad_ch [CODE_CHARS];
	logic       bad;
	logic [DIR_AW-1:0] prefix;
	logic [6:0]        suffix;

	// Split the text into characters, first character in the top byte.
	always_comb begin
		for (int i = 0; i < CODE_CHARS; i++) begin
			ch[i]     = zip_text[8*(CODE_CHARS-1-i) +: 8];
			bad_ch[i] = (ch[i] < CHAR_ZERO) || (ch[i] > CHAR_NINE);
			digit[i]  = 4'(ch[i] - CHAR_ZERO);
		end
	end

	// Any non-digit or a non-zero terminator makes the code invalid.
	always_comb begin
		bad = (zip_terminator != 8'd0);
		for (int i = 0; i < CODE_CHARS; i++) begin
			bad = bad | bad_ch[i];
		end
	end

	// Prefix from the first three digits, suffix from the last two.
	assign prefix = DIR_AW'(DIR_AW'(digit[0]) * DIR_AW'(100))
		+ DIR_AW'(DIR_AW'(digit[1]) * DIR_AW'(10))
		+ DIR_AW'(digit[2]);
	assign suffix = 7'(7'(digit[3]) * 7'(10)) + 7'(digit[4]);

	// Hold the decoded code for the sequencer.
	always_ff @(posedge clk) begin
		if (load) begin
			dec_q.bad    <= bad;
			dec_q.prefix <= prefix;
			dec_q.suffix <= suffix;
		end
	end

endmodule

// ===== hdl/prefix_bucket_zip_lookup_unit.sv =====
// Top level of the prefix bucket code lookup: stores, sequencer and result register.
//
//   Channel   Ports                       Direction  Handshake
//   input     start, busy, item           in         taken when start high and busy low
//   result    done, result                out        one cycle strobe, no back-pressure
//   config    record_count_we/_wdata      in         written when the write enable is high
//
// Load beats write the directory or the record store at the accepting edge and
// leave busy low. A lookup passes through the decode, directory start, directory
// end and scan states; the scan reads one record per cycle, at most the bucket size.
// An invalid code is answered from decode, a corrupt or empty bucket from directory end.
// Reset clears the sequencer and record_count; both stores are undefined until written.
module prefix_bucket_zip_lookup_unit
	import pbzl_pkg::*;
#(
	parameter int RECORD_SLOTS = RECORD_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  item_t       item,
	output logic        done,
	output result_t     result,
	input  logic        record_count_we,
	input  logic [15:0] record_count_wdata
);

	localparam int REC_AW = (RECORD_SLOTS > 1) ? $clog2(RECORD_SLOTS) : 1;

	state_t state_q, state_d;
	logic [15:0] record_count_q;
	logic        accept;
	dec_t        dec_q;

	logic [15:0]       dir_mem [DIR_SLOTS];
	logic [15:0]       dir_rd_q;
	logic [DIR_AW-1:0] dir_rd_addr;
	rec_t              rec_mem [RECORD_SLOTS];
	rec_t              rec_rd_q;

	logic [15:0] idx_q;
	logic [15:0] end_q;
	logic        rd_pend_q;
	logic        issue;
	logic        match;
	logic        corrupt;
	logic        emit;
	logic [1:0]  emit_status;
	logic        done_q;
	result_t     result_q;

	assign accept = start & ~busy;
	assign busy   = (state_q != ST_IDLE);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_count_q <= 16'd0;
		end else if (record_count_we) begin
			record_count_q <= record_count_wdata;
		end
	end

	// Code text decoder, loaded with every accepted lookup.
	pbzl_decode u_decode (
		.clk            (clk),
		.load           (accept && item.mode == MODE_LOOKUP),
		.zip_text       (item.zip_text),
		.zip_terminator (item.zip_terminator),
		.dec_q          (dec_q)
	);

	// Directory store: written by load beats, one registered read port.
	always_ff @(posedge clk) begin
		if (accept && item.mode == MODE_DIR_WRITE && item.load_index < 16'(DIR_SLOTS)) begin
			dir_mem[item.load_index[DIR_AW-1:0]] <= item.dir_value;
		end
		dir_rd_q <= dir_mem[dir_rd_addr];
	end

	// Record store: written by load beats, read at the scan index.
	always_ff @(posedge clk) begin
		if (accept && item.mode == MODE_REC_WRITE
			&& {1'b0, item.load_index} < 17'(RECORD_SLOTS)) begin
			rec_mem[item.load_index[REC_AW-1:0]] <= {item.rec_suffix, item.rec_latitude,
				item.rec_longitude};
		end
		rec_rd_q <= rec_mem[idx_q[REC_AW-1:0]];
	end

	// Bucket checks and the shared suffix compare.
	assign corrupt = (idx_q > dir_rd_q) || (dir_rd_q > record_count_q)
		|| ({1'b0, dir_rd_q} > 17'(RECORD_SLOTS));
	assign issue   = (idx_q < end_q);
	assign match   = rd_pend_q && (rec_rd_q.suffix == {1'b0, dec_q.suffix});

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && item.mode == MODE_LOOKUP) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = dec_q.bad ? ST_IDLE : ST_DIR_START;
			end
			ST_DIR_START: begin
				state_d = ST_DIR_END;
			end
			ST_DIR_END: begin
				state_d = (corrupt || idx_q == dir_rd_q) ? ST_IDLE : ST_SCAN;
			end
			ST_SCAN: begin
				if (match || !issue) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs: directory address and the result to emit.
	always_comb begin
		dir_rd_addr = dec_q.prefix;
		emit        = 1'b0;
		emit_status = STATUS_FOUND;
		unique case (state_q)
			ST_IDLE: begin
				dir_rd_addr = dec_q.prefix;
			end
			ST_DECODE: begin
				dir_rd_addr = dec_q.prefix;
				emit        = dec_q.bad;
				emit_status = STATUS_INVALID;
			end
			ST_DIR_START: begin
				dir_rd_addr = dec_q.prefix + DIR_AW'(1);
			end
			ST_DIR_END: begin
				if (corrupt) begin
					emit        = 1'b1;
					emit_status = STATUS_CORRUPT;
				end else if (idx_q == dir_rd_q) begin
					emit        = 1'b1;
					emit_status = STATUS_NOT_FOUND;
				end
			end
			ST_SCAN: begin
				if (match) begin
					emit        = 1'b1;
					emit_status = STATUS_FOUND;
				end else if (!issue) begin
					emit        = 1'b1;
					emit_status = STATUS_NOT_FOUND;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_pend_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_pend_q <= (state_q == ST_SCAN) && issue;
			done_q    <= emit;
		end
	end

	// Scan index and bucket end.
	always_ff @(posedge clk) begin
		if (state_q == ST_DIR_START) begin
			idx_q <= dir_rd_q;
		end else if (state_q == ST_SCAN && issue) begin
			idx_q <= idx_q + 16'd1;
		end
		if (state_q == ST_DIR_END) begin
			end_q <= dir_rd_q;
		end
	end

	// Result register: coordinates are zero unless a record matched.
	always_ff @(posedge clk) begin
		if (emit) begin
			result_q.status <= emit_status;
			if (emit_status == STATUS_FOUND) begin
				result_q.latitude  <= rec_rd_q.latitude;
				result_q.longitude <= rec_rd_q.longitude;
			end else begin
				result_q.latitude  <= 16'sd0;
				result_q.longitude <= 16'sd0;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef ASSERT_OFF
	// A result beat is only ever shown once the sequencer has returned to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result strobe while the sequencer is still busy");

	// An accepted lookup always enters the decode step.
	a_lookup_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.mode == MODE_LOOKUP) |=> (state_q == ST_DECODE))
		else $error("accepted lookup did not start the sequencer");

	// The scan index never runs past the bucket end.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (idx_q <= end_q))
		else $error("scan index beyond bucket end");

	// Coordinates are zero on every result that is not a match.
	a_zero_coords: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.status != STATUS_FOUND)
		|-> (result_q.latitude == 16'sd0 && result_q.longitude == 16'sd0))
		else $error("non-zero coordinates on a failed lookup");

	// A read is only pending while scanning.
	a_pend_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> $past(state_q == ST_SCAN))
		else $error("record read pending outside the scan");
`endif

endmodule

// ===== bench/tb_prefix_bucket_zip_lookup_unit.sv =====
// Self-checking testbench for the prefix bucket code lookup unit.
module tb_prefix_bucket_zip_lookup_unit;
	import pbzl_pkg::*;

	// The mode value that the block must ignore.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// Run shape and limits.
	localparam int RANDOM_ITEMS   = 1600;
	localparam int SCAN_CAP       = 100;
	localparam int SETTLE_CYCLES  = 4;
	localparam int DRAIN_CYCLES   = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 50;

	// Answers that can be read straight off the directed rows.
	localparam result_t ANS_NONE    = '0;
	localparam result_t ANS_INVALID = '{STATUS_INVALID, 16'sh0000, 16'sh0000};
	localparam result_t ANS_CORRUPT = '{STATUS_CORRUPT, 16'sh0000, 16'sh0000};
	localparam result_t ANS_MISSING = '{STATUS_NOT_FOUND, 16'sh0000, 16'sh0000};
	localparam result_t ANS_REC0    = '{STATUS_FOUND, 16'sh7FFF, 16'sh8000};
	localparam result_t ANS_REC1    = '{STATUS_FOUND, 16'sh8000, 16'sh7FFF};

	typedef enum {ROW_CFG, ROW_DIR, ROW_REC, ROW_CODE, ROW_SPARE} row_kind_t;

	// One directed step: slot and value serve loads, value alone a register write.
	typedef struct {
		row_kind_t          kind;
		logic [15:0]        slot;
		logic [15:0]        value;
		logic signed [15:0] lat;
		logic signed [15:0] lon;
		logic [39:0]        text;
		logic [7:0]         term;
		bit                 typed;
		result_t            want;
	} plan_row_t;

	localparam int PLAN_ROWS = 26;

	plan_row_t directed_plan [PLAN_ROWS] = '{
		'{ROW_CODE,  16'd0,    16'd0,      16'sh0,    16'sh0,    "1234A", 8'h00, 1'b1, ANS_INVALID},
		'{ROW_CODE,  16'd0,    16'd0,      16'sh0,    16'sh0,    "12345", 8'h01, 1'b1, ANS_INVALID},
		'{ROW_CODE,  16'd0,    16'd0,      16'sh0,    16'sh0,    "/9999", 8'h00, 1'b1, ANS_INVALID},
		'{ROW_CODE,  16'd0,    16'd0,      16'sh0,    16'sh0,    "9999:", 8'h00, 1'b1, ANS_INVALID},
		'{ROW_CODE,  16'd0,    16'd0,      16'sh0,    16'sh0,    "00000", 8'hFF, 1'b1, ANS_INVALID},
		'{ROW_SPARE, 16'd0,    16'd0,      16'sh0,    16'sh0,    40'h0,   8'h00, 1'b0, ANS_NONE},
		'{ROW_DIR,   16'd1001, 16'hFFFF,   16'sh0,    16'sh0,    40'h0,   8'h00, 1'b0, ANS_NONE},
		'{ROW_DIR,   16'd0,    16'd0,      16'sh0,    16'sh0,    40'h0,   8'h00, 1'b0, ANS_NONE},
		'{ROW_DIR,   16'd1,    16'd3,      16'sh0,    16'sh0,    40'h0,   8'h00, 1'b0, ANS_NONE},
		'{ROW_REC,   16'd0,    16'd5,      16'sh7FFF, 16'sh8000, 40'h0,   8'h00, 1'b0, ANS_NONE},
		'{ROW_REC,   16'd1,    16'd0,      16'sh8000, 16'sh7FFF, 40'h0,   8'h00, 1'b0, ANS_NONE},
		'{ROW_REC,   16'd2,    16'd99,     16'shFFFF, 16'sh0001, 40'h0,   8'h00, 1'b0, ANS_NONE},
		'{ROW_CODE,  16'd0,    16'd0,      16'sh0,    16'sh0,    "00000", 8'h00, 1'b1, ANS_CORRUPT},
		'{ROW_CFG,   16'd0,    16'd3,      16'sh0,    16'sh0,    40'h0,   8'h00, 1'b0, ANS_NONE},
		'{ROW_CODE,  16'd0,    16'd0,      16'sh0,    16'sh0,    "00000", 8'h00, 1'b1, ANS_REC1},
		'{ROW_CODE,  16'd0,    16'd0,      16'sh0,    16'sh0,    "00005", 8'h00, 1'b1, ANS_REC0},
		'{ROW_CODE,  16'd0,    16'd0,      16'sh0,    16'sh0,    "00099", 8'h00, 1'b0, ANS_NONE},
		'{ROW_CODE,  16'd0,    16'd0,      16'sh0,    16'sh0,    "00042", 8'h00, 1'b1, ANS_MISSING},
		'{ROW_DIR,   16'd2,    16'd3,      16'sh0,    16'sh0,    40'h0,   8'h00, 1'b0, ANS_NONE},
		'{ROW_CODE,  16'd0,    16'd0,      16'sh0,    16'sh0,    "00100", 8'h00, 1'b1, ANS_MISSING},
		'{ROW_DIR,   16'd999,  16'd3,      16'sh0,    16'sh0,    40'h0,   8'h00, 1'b0, ANS_NONE},
		'{ROW_DIR,   16'd1000, 16'd1,      16'sh0,    16'sh0,    40'h0,   8'h00, 1'b0, ANS_NONE},
		'{ROW_CODE,  16'd0,    16'd0,      16'sh0,    16'sh0,    "99999", 8'h00, 1'b1, ANS_CORRUPT},
		'{ROW_CFG,   16'd0,    16'hFFFF,   16'sh0,    16'sh0,    40'h0,   8'h00, 1'b0, ANS_NONE},
		'{ROW_CFG,   16'd0,    16'd2,      16'sh0,    16'sh0,    40'h0,   8'h00, 1'b0, ANS_NONE},
		'{ROW_CODE,  16'd0,    16'd0,      16'sh0,    16'sh0,    "00000", 8'h00, 1'b1, ANS_CORRUPT}
	};

	// Block ports.
	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	item_t       item;
	logic        done;
	result_t     result;
	logic        record_count_we;
	logic [15:0] record_count_wdata;

	// Shadow copies of the stores and the register, updated as beats are taken.
	logic [15:0] dir_copy [DIR_SLOTS];
	bit          dir_written [DIR_SLOTS];
	rec_t        rec_copy [RECORD_SLOTS_DEF];
	bit          rec_written [RECORD_SLOTS_DEF];
	logic [15:0] count_copy = 16'd0;

	// Lookup answers still to come, oldest first.
	result_t answers_due [$];
	result_t next_due;

	int fail_count   = 0;
	int quiet_cycles = 0;
	bit start_high   = 1'b0;
	int burst_left   = 0;
	int items_sent   = 0;
	int used_prefixes [$];
	int bucket_suffixes [$];

	prefix_bucket_zip_lookup_unit u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.item               (item),
		.done               (done),
		.result             (result),
		.record_count_we    (record_count_we),
		.record_count_wdata (record_count_wdata)
	);

	always #2 clk = ~clk;

	// Splits five digit characters into prefix and suffix; false on bad text.
	function automatic bit decode_code(logic [39:0] text, logic [7:0] term,
			output int prefix, output int suffix);
		logic [7:0] ch;
		int         d [CODE_CHARS];
		for (int i = 0; i < CODE_CHARS; i++) begin
			ch = text[8*(CODE_CHARS-1-i) +: 8];
			if (ch < CHAR_ZERO || ch > CHAR_NINE)
				return 1'b0;
			d[i] = ch - CHAR_ZERO;
		end
		if (term != 8'h00)
			return 1'b0;
		prefix = d[0] * 100 + d[1] * 10 + d[2];
		suffix = d[3] * 10 + d[4];
		return 1'b1;
	endfunction

	// Walks one bucket and gives the answer. The return value tells whether
	// every entry read had been written and the scan stayed short.
	function automatic bit walk_bucket(int prefix, int suffix, output result_t r);
		int lo;
		int hi;
		bit clean;
		clean = dir_written[prefix] && dir_written[prefix+1];
		lo = dir_copy[prefix];
		hi = dir_copy[prefix+1];
		r = '0;
		if (lo > hi || hi > count_copy) begin
			r.status = STATUS_CORRUPT;
			return clean;
		end
		r.status = STATUS_NOT_FOUND;
		for (int idx = lo; idx < hi && clean; idx++) begin
			if (!rec_written[idx] || idx - lo >= SCAN_CAP)
				clean = 1'b0;
			else if (rec_copy[idx].suffix == suffix) begin
				r = '{STATUS_FOUND, rec_copy[idx].latitude, rec_copy[idx].longitude};
				return clean;
			end
		end
		return clean;
	endfunction

	// Expected answer to one lookup beat.
	function automatic result_t resolve_code(logic [39:0] text, logic [7:0] term);
		int      prefix;
		int      suffix;
		result_t r;
		r = '0;
		if (!decode_code(text, term, prefix, suffix))
			r.status = STATUS_INVALID;
		else
			void'(walk_bucket(prefix, suffix, r));
		return r;
	endfunction

	// True when a lookup touches only written entries and stays within the scan cap.
	function automatic bit lookup_is_clean(logic [39:0] text, logic [7:0] term);
		int      prefix;
		int      suffix;
		result_t r;
		if (!decode_code(text, term, prefix, suffix))
			return 1'b1;
		return walk_bucket(prefix, suffix, r);
	endfunction

	function automatic logic [39:0] code_text(int prefix, int suffix);
		return {8'(CHAR_ZERO + prefix / 100), 8'(CHAR_ZERO + (prefix / 10) % 10),
			8'(CHAR_ZERO + prefix % 10), 8'(CHAR_ZERO + suffix / 10),
			8'(CHAR_ZERO + suffix % 10)};
	endfunction

	// A beat with every field random; callers then set what the mode uses.
	function automatic item_t random_fill(logic [1:0] mode);
		item_t b;
		b.mode           = mode;
		b.load_index     = 16'($urandom);
		b.dir_value      = 16'($urandom);
		b.rec_suffix     = 8'($urandom);
		b.rec_latitude   = 16'($urandom);
		b.rec_longitude  = 16'($urandom);
		b.zip_text       = {8'($urandom), 32'($urandom)};
		b.zip_terminator = 8'($urandom);
		return b;
	endfunction

	function automatic item_t dir_beat(int slot, int value);
		item_t b;
		b = random_fill(MODE_DIR_WRITE);
		b.load_index = 16'(slot);
		b.dir_value  = 16'(value);
		return b;
	endfunction

	function automatic item_t rec_beat(int slot, int suffix);
		item_t b;
		b = random_fill(MODE_REC_WRITE);
		b.load_index = 16'(slot);
		b.rec_suffix = 8'(suffix);
		return b;
	endfunction

	function automatic item_t code_beat(logic [39:0] text, logic [7:0] term);
		item_t b;
		b = random_fill(MODE_LOOKUP);
		b.zip_text       = text;
		b.zip_terminator = term;
		return b;
	endfunction

	task automatic report_mismatch(string what);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0t: mismatch: %s", $time, what);
	endtask

	// Updates the shadow state for a taken beat and queues any answer.
	task automatic apply_beat(item_t b, bit typed, result_t want);
		case (b.mode)
			MODE_DIR_WRITE: begin
				if (b.load_index < DIR_SLOTS) begin
					dir_copy[b.load_index]    = b.dir_value;
					dir_written[b.load_index] = 1'b1;
				end
			end
			MODE_REC_WRITE: begin
				rec_copy[b.load_index]    = '{b.rec_suffix, b.rec_latitude, b.rec_longitude};
				rec_written[b.load_index] = 1'b1;
			end
			MODE_LOOKUP: begin
				answers_due.push_back(typed ? want : resolve_code(b.zip_text, b.zip_terminator));
			end
			default: ;
		endcase
	endtask

	task automatic drop_start();
		if (start_high) begin
			start      <= 1'b0;
			start_high = 1'b0;
		end
	endtask

	// Presents one beat and returns at the edge that takes it; start stays high.
	task automatic send_beat(item_t b, bit typed, result_t want);
		start      <= 1'b1;
		start_high = 1'b1;
		item       <= b;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		apply_beat(b, typed, want);
	endtask

	// Bursts of beats with random gaps, sometimes long quiet or busy stretches.
	task automatic pace();
		int gap;
		if (burst_left > 0)
			burst_left--;
		else begin
			drop_start();
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 4);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 160)
				: $urandom_range(0, 12);
		end
	endtask

	// Register writes happen only with no lookup in flight.
	task automatic write_count(logic [15:0] value);
		drop_start();
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		record_count_we    <= 1'b1;
		record_count_wdata <= value;
		@(posedge clk);
		count_copy = value;
		record_count_we <= 1'b0;
	endtask

	// A random-part beat; ignored beats do not count towards the run length.
	task automatic issue(item_t b);
		send_beat(b, 1'b0, ANS_NONE);
		if (!(b.mode == MODE_UNUSED || (b.mode == MODE_DIR_WRITE && b.load_index >= DIR_SLOTS)))
			items_sent++;
		pace();
	endtask

	// Occasional stray beats: unused mode, out-of-range slot, stray record.
	task automatic stray_beat();
		if ($urandom_range(0, 11) == 0) begin
			case ($urandom_range(0, 2))
				0: issue(random_fill(MODE_UNUSED));
				1: issue(dir_beat($urandom_range(DIR_SLOTS, 65535), $urandom_range(0, 65535)));
				default: issue(rec_beat($urandom_range(0, 65535), $urandom_range(0, 255)));
			endcase
		end
	endtask

	// Result checking: every strobe must match the oldest queued answer.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (answers_due.size() == 0)
				report_mismatch("result beat with no lookup outstanding");
			else begin
				next_due = answers_due.pop_front();
				if (result.status !== next_due.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						result.status, next_due.status));
				if (result.latitude !== next_due.latitude)
					report_mismatch($sformatf("latitude %0d, expected %0d",
						result.latitude, next_due.latitude));
				if (result.longitude !== next_due.longitude)
					report_mismatch($sformatf("longitude %0d, expected %0d",
						result.longitude, next_due.longitude));
			end
		end
	end

	// Watchdog: too long without a beat taken or a result given ends the run.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		plan_row_t   row;
		item_t       b;
		int          p;
		int          n;
		int          lo;
		int          hi;
		int          suf;
		int          lookups;
		int          episode;
		logic [15:0] new_count;
		logic [39:0] text;
		logic [7:0]  term;

		start              = 1'b0;
		item               = '0;
		record_count_we    = 1'b0;
		record_count_wdata = 16'd0;
		arst_n             = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: error codes, extremes, empty and corrupt buckets.
		foreach (directed_plan[i]) begin
			row = directed_plan[i];
			if (row.kind == ROW_CFG)
				write_count(row.value);
			else begin
				case (row.kind)
					ROW_DIR:  b = dir_beat(row.slot, row.value);
					ROW_REC: begin
						b = rec_beat(row.slot, row.value);
						b.rec_latitude  = row.lat;
						b.rec_longitude = row.lon;
					end
					ROW_CODE: b = code_beat(row.text, row.term);
					default:  b = random_fill(MODE_UNUSED);
				endcase
				send_beat(b, row.typed, row.want);
				pace();
			end
		end

		// Random part: each round builds one bucket, fills it and looks codes up in it.
		episode = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (episode % 10 == 0) begin
				case ($urandom_range(0, 5))
					0: new_count = 16'd0;
					1: new_count = 16'hFFFF;
					2: new_count = 16'($urandom_range(0, 3000));
					default: new_count = 16'($urandom_range(3000, 65535));
				endcase
				write_count(episode == 0 ? 16'd0 : new_count);
			end

			p  = $urandom_range(0, 999);
			n  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, SCAN_CAP) : $urandom_range(0, 6);
			lo = ($urandom_range(0, 11) == 0) ? 65535 - n - $urandom_range(0, 2)
				: $urandom_range(0, 4000);
			hi = lo + n;

			// Bucket bounds, now and then reversed so that start exceeds end.
			if (n > 0 && $urandom_range(0, 9) == 0) begin
				issue(dir_beat(p, hi));
				issue(dir_beat(p + 1, lo));
			end else if ($urandom_range(0, 1) == 0) begin
				issue(dir_beat(p, lo));
				issue(dir_beat(p + 1, hi));
			end else begin
				issue(dir_beat(p + 1, hi));
				issue(dir_beat(p, lo));
			end

			// Bucket contents; small suffixes repeat so that the first match counts.
			bucket_suffixes.delete();
			for (int k = lo; k < hi; k++) begin
				if ($urandom_range(0, 3) == 0)
					suf = $urandom_range(0, 3);
				else
					suf = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 255)
						: $urandom_range(0, 99);
				bucket_suffixes.push_back(suf % 100);
				issue(rec_beat(k, suf));
				stray_beat();
			end

			// Lookups, mostly into this bucket, some broken, some into older buckets.
			lookups = $urandom_range(1, 6);
			for (int j = 0; j < lookups; j++) begin
				if (bucket_suffixes.size() != 0 && $urandom_range(0, 2) != 0)
					suf = bucket_suffixes[$urandom_range(0, bucket_suffixes.size() - 1)];
				else
					suf = $urandom_range(0, 99);
				text = code_text(p, suf);
				term = 8'h00;
				case ($urandom_range(0, 15))
					0: text = {8'($urandom), 32'($urandom)};
					1: term = 8'($urandom_range(1, 255));
					2: text[8*$urandom_range(0, CODE_CHARS - 1) +: 8] = 8'($urandom);
					3, 4: begin
						if (used_prefixes.size() != 0)
							text = code_text(used_prefixes[$urandom_range(0,
								used_prefixes.size() - 1)], $urandom_range(0, 99));
					end
					default: ;
				endcase
				if (!lookup_is_clean(text, term)) begin
					text = code_text(p, suf);
					term = 8'h00;
				end
				issue(code_beat(text, term));
				stray_beat();
			end

			used_prefixes.push_back(p);
			episode++;
		end

		// Drain: wait for every answer, then a little longer for strays.
		drop_start();
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
